// File: rtl/bzn_pkg.sv
// Package for the bug-zero navigation step: types, constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bzn_pkg;

  localparam int PosBitsDefault     = 11;
  localparam int CordicStepsDefault = 14;
  localparam int MaxSteps           = 20;
  localparam int AngBits            = 30;

  localparam logic [AngBits-1:0] HalfPiQ24 = 30'd26353589;

  localparam logic [1:0] ModeDrive  = 2'd0;
  localparam logic [1:0] ModeLeft   = 2'd1;
  localparam logic [1:0] ModeRight  = 2'd2;
  localparam logic [1:0] ModeFinish = 2'd3;

  localparam logic signed [9:0] SpdOne     = 10'sd256;
  localparam logic signed [9:0] SpdHalf    = 10'sd128;
  localparam logic signed [9:0] SpdQuarter = 10'sd64;
  localparam logic signed [9:0] SpdTenth   = 10'sd26;

  localparam logic [2:0] RegTargetX  = 3'd0;
  localparam logic [2:0] RegTargetY  = 3'd1;
  localparam logic [2:0] RegHeadTol  = 3'd2;
  localparam logic [2:0] RegObstacle = 3'd3;
  localparam logic [2:0] RegNearWall = 3'd4;
  localparam logic [2:0] RegFarWall  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_OUT
  } state_t;

  function automatic logic [AngBits-1:0] atan_q24(input logic [4:0] i);
    logic [AngBits-1:0] v;
    begin
      unique case (i)
        5'd0:    v = 30'd13176795;
        5'd1:    v = 30'd7778716;
        5'd2:    v = 30'd4110060;
        5'd3:    v = 30'd2086331;
        5'd4:    v = 30'd1047214;
        5'd5:    v = 30'd524117;
        5'd6:    v = 30'd262123;
        5'd7:    v = 30'd131069;
        5'd8:    v = 30'd65536;
        5'd9:    v = 30'd32768;
        5'd10:   v = 30'd16384;
        5'd11:   v = 30'd8192;
        5'd12:   v = 30'd4096;
        5'd13:   v = 30'd2048;
        5'd14:   v = 30'd1024;
        5'd15:   v = 30'd512;
        5'd16:   v = 30'd256;
        5'd17:   v = 30'd128;
        5'd18:   v = 30'd64;
        5'd19:   v = 30'd32;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/bzn_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation a cycle, gives atan2 in Q3.12.
// Depends on bzn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bzn_cordic #(
  parameter int POS_BITS     = bzn_pkg::PosBitsDefault,
  parameter int CORDIC_STEPS = bzn_pkg::CordicStepsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [POS_BITS:0]   dx,
  input  wire logic signed [POS_BITS:0]   dy,
  output logic                            done,
  output logic signed [14:0]              bearing
);
  localparam int WB = POS_BITS + 14;
  localparam int SB = $clog2(CORDIC_STEPS + 1);

  logic signed [WB-1:0] x, y;
  logic signed [bzn_pkg::AngBits-1:0] z;
  logic [SB-1:0] step;
  logic busy;
  logic zero;

  logic signed [WB-1:0] xs, ys, dxw, dyw;
  logic signed [bzn_pkg::AngBits-1:0] at, zr;

  always_comb begin
    xs  = x >>> step;
    ys  = y >>> step;
    at  = bzn_pkg::atan_q24(5'(step));
    dxw = WB'(dx) <<< 10;
    dyw = WB'(dy) <<< 10;
    zr  = z + bzn_pkg::AngBits'(2048);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        zero <= (dx == 0 && dy == 0);
        if (dx < 0) begin
          if (dy >= 0) begin
            x <= dyw; y <= -dxw; z <= bzn_pkg::HalfPiQ24;
          end else begin
            x <= -dyw; y <= dxw; z <= -bzn_pkg::HalfPiQ24;
          end
        end else begin
          x <= dxw; y <= dyw; z <= '0;
        end
      end else if (busy) begin
        if (step == SB'(CORDIC_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (zero) bearing <= '0;
          else bearing <= zr[26:12];
        end else begin
          if (y > 0) begin
            x <= x + ys; y <= y - xs; z <= z + at;
          end else begin
            x <= x - ys; y <= y + xs; z <= z - at;
          end
          step <= step + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/bzn_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on bzn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bzn_isqrt #(
  parameter int POS_BITS = bzn_pkg::PosBitsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [2*POS_BITS+1:0]      radicand,
  output logic                            done,
  output logic [POS_BITS:0]               root
);
  localparam int NB = 2 * POS_BITS + 2;
  localparam int RB = POS_BITS + 1;
  localparam int CB = $clog2(RB + 1);

  logic [RB-1:0] res;
  logic [CB-1:0] cnt;
  logic busy;
  logic [RB+1:0] trial;

  always_comb trial = {res, 2'b01};

  // pr holds the partial remainder, radicand bits fed from a shifter
  logic [NB-1:0] src;
  logic [RB+1:0] pr, pr_sh;
  always_comb pr_sh = {pr[RB-1:0], src[NB-1 -: 2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        src  <= radicand;
        pr   <= '0;
        res  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CB'(RB)) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= res;
        end else begin
          if (pr_sh >= trial) begin
            pr  <= pr_sh - trial;
            res <= {res[RB-2:0], 1'b1};
          end else begin
            pr  <= pr_sh;
            res <= {res[RB-2:0], 1'b0};
          end
          src <= src << 2;
          cnt <= cnt + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/bug_zero_navigation_step_top.sv
// Top level of the bug-zero navigation step: config registers, sequencer, mode logic.
// Depends on bzn_pkg, bzn_cordic, bzn_isqrt.
`timescale 1ns / 1ps
`default_nettype none
// One input transfer waits from acceptance until both the iterative CORDIC
// (CORDIC_STEPS steps) and the square root (POS_BITS + 1 steps, started once the
// squares are registered, via sq_go and sq_go2) are done; both run alongside, and
// the slower one sets when the result is offered. s_tready is low while an
// item is in work and while a result waits on the master side. The mode is
// held between items; once finished it stays so until reset.
module bug_zero_navigation_step_top #(
  parameter int POS_BITS     = bzn_pkg::PosBitsDefault,
  parameter int CORDIC_STEPS = bzn_pkg::CordicStepsDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // robot_x, robot_y, heading, range_front, range_left, range_right, zero fill
  input  wire logic [((2*POS_BITS+63+7)/8)*8-1:0] s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // linear_speed, angular_speed, nav_mode, arrived, zero fill
  output logic [23:0]            m_tdata,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  localparam int P = POS_BITS;

  logic signed [P-1:0] target_x, target_y;
  logic [12:0] heading_tolerance;
  logic [15:0] obstacle_range, near_wall_range, far_wall_range;
  logic signed [14:0] heading;
  logic [15:0] range_front, range_left, range_right;
  logic [1:0] mode, mode_next;
  bzn_pkg::state_t state, state_next;

  logic signed [P:0] dx, dy;
  logic [2*P+1:0] dsq;
  logic start;
  logic c_done, q_done, c_got, q_got;
  logic signed [14:0] brg;
  logic [P:0] distance;
  logic signed [9:0] lin, ang;
  logic arrived;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == bzn_pkg::ST_IDLE);
  assign m_tvalid  = (state == bzn_pkg::ST_OUT);
  assign start     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      heading_tolerance <= 13'd205;
      obstacle_range <= 16'd256;
      near_wall_range <= 16'd128;
      far_wall_range <= 16'd333;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bzn_pkg::RegTargetX:  target_x <= cfg_data[P-1:0];
        bzn_pkg::RegTargetY:  target_y <= cfg_data[P-1:0];
        bzn_pkg::RegHeadTol:  heading_tolerance <= cfg_data[12:0];
        bzn_pkg::RegObstacle: obstacle_range <= cfg_data;
        bzn_pkg::RegNearWall: near_wall_range <= cfg_data;
        bzn_pkg::RegFarWall:  far_wall_range <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx = (P+1)'(target_x) - (P+1)'($signed(s_tdata[P-1:0]));
    dy = (P+1)'(target_y) - (P+1)'($signed(s_tdata[2*P-1:P]));
  end

  logic signed [P:0] dx_r, dy_r;
  logic [2*P+1:0] sq_x;
  always_ff @(posedge clk) begin
    if (start) begin
      heading     <= s_tdata[2*P+14:2*P];
      range_front <= s_tdata[2*P+30:2*P+15];
      range_left  <= s_tdata[2*P+46:2*P+31];
      range_right <= s_tdata[2*P+62:2*P+47];
      dx_r <= dx;
      dy_r <= dy;
    end
  end

  // squares registered before the sum, the root starts in the following cycle
  logic sq_go, sq_go2;
  logic [2*P+1:0] sq_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_go <= 1'b0;
      sq_go2 <= 1'b0;
    end else begin
      sq_go <= start;
      sq_go2 <= sq_go;
    end
    sq_x <= (2*P+2)'(dx_r * dx_r);
    sq_y <= (2*P+2)'(dy_r * dy_r);
  end
  assign dsq = sq_x + sq_y;

  bzn_cordic #(.POS_BITS(P), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(start), .dx(dx), .dy(dy),
    .done(c_done), .bearing(brg)
  );

  bzn_isqrt #(.POS_BITS(P)) u_isqrt (
    .clk(clk), .rst(rst), .start(sq_go2), .radicand(dsq),
    .done(q_done), .root(distance)
  );

  always_ff @(posedge clk) begin
    if (rst || start) begin
      c_got <= 1'b0;
      q_got <= 1'b0;
    end else begin
      if (c_done) c_got <= 1'b1;
      if (q_done) q_got <= 1'b1;
    end
  end

  logic signed [16:0] lo_b, hi_b, head_w;
  logic facing, leave;
  logic [P+16:0] dist_sh;
  logic signed [9:0] lin_c, ang_c;

  always_comb begin
    head_w  = 17'(heading);
    lo_b    = 17'(brg) - 17'($signed({1'b0, heading_tolerance}));
    hi_b    = 17'(brg) + 17'($signed({1'b0, heading_tolerance}));
    facing  = (lo_b <= head_w) && (head_w <= hi_b);
    dist_sh = (P+17)'(distance) << 8;
    leave   = facing && ((P+17)'(range_front) > dist_sh);
    mode_next = mode;
    lin_c = '0;
    ang_c = '0;
    unique case (mode)
      bzn_pkg::ModeFinish: ;
      bzn_pkg::ModeLeft: begin
        priority if (leave) begin
          mode_next = bzn_pkg::ModeDrive; ang_c = bzn_pkg::SpdHalf; lin_c = bzn_pkg::SpdOne;
        end else if (range_left <= near_wall_range) begin
          ang_c = -bzn_pkg::SpdOne; lin_c = bzn_pkg::SpdTenth;
        end else if (range_left <= far_wall_range) begin
          lin_c = bzn_pkg::SpdHalf; ang_c = -bzn_pkg::SpdQuarter;
        end else begin
          ang_c = bzn_pkg::SpdHalf; lin_c = bzn_pkg::SpdHalf;
        end
      end
      bzn_pkg::ModeRight: begin
        priority if (leave) begin
          mode_next = bzn_pkg::ModeDrive; ang_c = -bzn_pkg::SpdHalf; lin_c = bzn_pkg::SpdOne;
        end else if (range_right <= near_wall_range) begin
          ang_c = bzn_pkg::SpdOne; lin_c = bzn_pkg::SpdTenth;
        end else if (range_right <= far_wall_range) begin
          lin_c = bzn_pkg::SpdHalf; ang_c = bzn_pkg::SpdQuarter;
        end else begin
          ang_c = -bzn_pkg::SpdHalf; lin_c = bzn_pkg::SpdHalf;
        end
      end
      default: begin
        if (facing && range_front <= obstacle_range)
          mode_next = (range_left < range_right) ? bzn_pkg::ModeLeft : bzn_pkg::ModeRight;
        if (!facing) begin
          ang_c = (17'(brg) > head_w) ? bzn_pkg::SpdHalf : -bzn_pkg::SpdHalf;
          lin_c = bzn_pkg::SpdHalf;
        end else begin
          lin_c = bzn_pkg::SpdOne;
        end
      end
    endcase
    if (distance == '0) begin
      mode_next = bzn_pkg::ModeFinish;
      lin_c = '0;
      ang_c = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bzn_pkg::ST_IDLE:   if (start) state_next = bzn_pkg::ST_CALC;
      bzn_pkg::ST_CALC:   if (c_got && q_got) state_next = bzn_pkg::ST_DECIDE;
      bzn_pkg::ST_DECIDE: state_next = bzn_pkg::ST_OUT;
      bzn_pkg::ST_OUT:    if (m_tready) state_next = bzn_pkg::ST_IDLE;
      default:            state_next = bzn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bzn_pkg::ST_IDLE;
      mode  <= bzn_pkg::ModeDrive;
    end else begin
      state <= state_next;
      if (state == bzn_pkg::ST_DECIDE) mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bzn_pkg::ST_DECIDE) begin
      lin <= lin_c;
      ang <= ang_c;
      arrived <= (distance == '0);
    end
  end

  assign m_tdata = {1'b0, arrived, mode, ang, lin};
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the bug-zero navigation step: directed and random control ticks
// against an in-bench predictor of bearing, distance, mode and speed commands.
// Depends on bzn_pkg and bug_zero_navigation_step_top.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [2:0] RegSpare = 3'd6;
  localparam logic [2:0] RegTop   = 3'd7;
  localparam int LIMIT = 400000;
  localparam longint ATAN_TAB [14] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                       262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048};

  typedef struct {
    logic signed [9:0] lin;
    logic signed [9:0] ang;
    logic [1:0]        mode;
    logic              arrived;
  } nav_cmd_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  // robot_x, robot_y, heading, range_front, range_left, range_right, zero fill
  logic [87:0] s_tdata;
  logic        m_tvalid, m_tready;
  // linear_speed, angular_speed, nav_mode, arrived, zero fill
  logic [23:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // predictor copy of registers and mode
  longint   tgt_x, tgt_y, head_tol, obst_rng, near_rng, far_rng;
  logic [1:0] nav_mode;
  nav_cmd_t cmd_q[$];
  int       errors, cycles, stall;
  bit       quiet;

  bug_zero_navigation_step_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint int_sqrt(longint n);
    longint res, b;
    res = 0;
    b = longint'(1) << 40;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // atan2(dy, dx) in Q3.12 via vectoring CORDIC in Q.24
  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 1024;
    y = dy * 1024;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = longint'(bzn_pkg::HalfPiQ24);
      end else begin
        t = -y; y = x; x = t; z = -longint'(bzn_pkg::HalfPiQ24);
      end
    end
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
      end
    end
    z = z + (longint'(4) << 24);
    return ((z + 2048) >>> 12) - (longint'(4) << 12);
  endfunction

  function automatic nav_cmd_t predict_cmd(longint rx, longint ry, longint hd,
                                           longint f, longint l, longint r);
    nav_cmd_t c;
    longint dx, dy, distance, brg;
    bit facing, leave;
    dx = tgt_x - rx;
    dy = tgt_y - ry;
    distance = int_sqrt(dx * dx + dy * dy);
    brg = bearing(dx, dy);
    facing = (brg - head_tol <= hd) && (hd <= brg + head_tol);
    leave = facing && (f > (distance << 8));
    c.lin = '0;
    c.ang = '0;
    case (nav_mode)
      bzn_pkg::ModeFinish: ;
      bzn_pkg::ModeLeft: begin
        if (leave) begin
          nav_mode = bzn_pkg::ModeDrive; c.ang = bzn_pkg::SpdHalf; c.lin = bzn_pkg::SpdOne;
        end else if (l <= near_rng) begin
          c.ang = -bzn_pkg::SpdOne; c.lin = bzn_pkg::SpdTenth;
        end else if (l <= far_rng) begin
          c.lin = bzn_pkg::SpdHalf; c.ang = -bzn_pkg::SpdQuarter;
        end else begin
          c.ang = bzn_pkg::SpdHalf; c.lin = bzn_pkg::SpdHalf;
        end
      end
      bzn_pkg::ModeRight: begin
        if (leave) begin
          nav_mode = bzn_pkg::ModeDrive; c.ang = -bzn_pkg::SpdHalf; c.lin = bzn_pkg::SpdOne;
        end else if (r <= near_rng) begin
          c.ang = bzn_pkg::SpdOne; c.lin = bzn_pkg::SpdTenth;
        end else if (r <= far_rng) begin
          c.lin = bzn_pkg::SpdHalf; c.ang = bzn_pkg::SpdQuarter;
        end else begin
          c.ang = -bzn_pkg::SpdHalf; c.lin = bzn_pkg::SpdHalf;
        end
      end
      default: begin
        if (facing && f <= obst_rng)
          nav_mode = (l < r) ? bzn_pkg::ModeLeft : bzn_pkg::ModeRight;
        if (!facing) begin
          c.ang = (brg > hd) ? bzn_pkg::SpdHalf : -bzn_pkg::SpdHalf;
          c.lin = bzn_pkg::SpdHalf;
        end else begin
          c.lin = bzn_pkg::SpdOne;
        end
      end
    endcase
    c.arrived = (distance == 0);
    if (c.arrived) begin
      nav_mode = bzn_pkg::ModeFinish; c.lin = '0; c.ang = '0;
    end
    c.mode = nav_mode;
    return c;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      nav_cmd_t w;
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (cmd_q.size() == 0) begin
        report("unexpected result", m_tdata, 0);
      end else begin
        w = cmd_q.pop_front();
        if ($signed(m_tdata[9:0]) != w.lin) report("linear_speed", $signed(m_tdata[9:0]), w.lin);
        if ($signed(m_tdata[19:10]) != w.ang)
          report("angular_speed", $signed(m_tdata[19:10]), w.ang);
        if (m_tdata[21:20] != w.mode) report("nav_mode", m_tdata[21:20], w.mode);
        if (m_tdata[22] != w.arrived) report("arrived", m_tdata[22], w.arrived);
      end
    end
  end

  always @(negedge clk) begin
    if (stall > 0) begin
      m_tready = 1'b0;
      stall--;
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic send_tick(longint rx, longint ry, longint hd, longint f, longint l, longint r);
    int gap;
    logic [10:0] xb, yb;
    logic [14:0] hb;
    xb = rx[10:0];
    yb = ry[10:0];
    hb = hd[14:0];
    s_tdata = '0;
    s_tdata[84:0] = {r[15:0], l[15:0], f[15:0], hb, yb, xb};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    cmd_q.push_back(predict_cmd($signed(xb), $signed(yb), $signed(hb), f, l, r));
    @(negedge clk);
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid = 1'b0;
    while (cmd_q.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bzn_pkg::RegTargetX:  tgt_x = longint'($signed(val[10:0]));
      bzn_pkg::RegTargetY:  tgt_y = longint'($signed(val[10:0]));
      bzn_pkg::RegHeadTol:  head_tol = val[12:0];
      bzn_pkg::RegObstacle: obst_rng = val;
      bzn_pkg::RegNearWall: near_rng = val;
      bzn_pkg::RegFarWall:  far_rng = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_target(longint tx, longint ty);
    write_reg(bzn_pkg::RegTargetX, {5'($urandom), tx[10:0]});
    write_reg(bzn_pkg::RegTargetY, {5'($urandom), ty[10:0]});
  endtask

  function automatic longint clampv(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // a value near a threshold, or anywhere
  function automatic longint around(longint t);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return clampv(t + $urandom_range(0, 6) - 3, 0, 65535);
  endfunction

  task automatic send_facing(longint rx, longint ry, longint f, longint l, longint r);
    send_tick(rx, ry, bearing(tgt_x - rx, tgt_y - ry), f, l, r);
  endtask

  task automatic test_directed;
    send_tick(5, 0, 0, 65535, 0, 0);
    send_tick(-1024, -1024, 16383, 0, 65535, 65535);
    send_tick(1023, 1023, -16384, 65535, 0, 65535);
    send_tick(1023, -1024, 12868, 300, 1, 2);
    send_tick(-3, 0, 0, 65535, 10, 20);
    // blocked ahead, left nearer: follow left
    send_tick(-3, 0, 0, 100, 10, 20);
    send_tick(-3, 0, 8000, 0, 50, 0);
    send_tick(-3, 0, -8000, 0, 200, 0);
    send_tick(-3, 0, 8000, 0, 65535, 0);
    send_tick(-3, 0, 0, 769, 0, 0);
    // equal sides: follow right
    send_tick(-3, 0, 0, 0, 300, 300);
    send_tick(-3, 0, 8000, 0, 0, 0);
    send_tick(-3, 0, 8000, 0, 0, 333);
    send_tick(-3, 0, 8000, 0, 0, 334);
    send_tick(-3, 0, 205, 768, 0, 0);
    send_tick(-3, 0, 206, 65535, 0, 0);
    send_tick(-3, 0, -205, 65535, 0, 0);
    drain();
  endtask

  task automatic test_config_extremes;
    write_target(-1024, 1023);
    write_reg(bzn_pkg::RegHeadTol, 16'hffff);
    write_reg(bzn_pkg::RegObstacle, 16'hffff);
    write_reg(bzn_pkg::RegNearWall, 16'hffff);
    write_reg(bzn_pkg::RegFarWall, 16'hffff);
    write_reg(RegSpare, 16'h0000);
    write_reg(RegTop, 16'hffff);
    send_tick(1023, -1024, 0, 65535, 0, 1);
    send_tick(1023, -1024, 0, 65535, 65535, 65535);
    drain();
    write_target(1023, -1024);
    write_reg(bzn_pkg::RegHeadTol, 0);
    write_reg(bzn_pkg::RegObstacle, 0);
    write_reg(bzn_pkg::RegNearWall, 0);
    write_reg(bzn_pkg::RegFarWall, 0);
    send_facing(-1024, 1023, 0, 5, 4);
    send_facing(-1024, 1023, 0, 0, 1);
    send_facing(-1024, 1023, 65535, 0, 0);
    drain();
  endtask

  task automatic random_tick;
    longint rx, ry, dx, dy, distance, brg, hd, f;
    if ($urandom_range(0, 3) == 0) begin
      rx = longint'($urandom_range(0, 2047)) - 1024;
      ry = longint'($urandom_range(0, 2047)) - 1024;
    end else begin
      rx = clampv(tgt_x + $urandom_range(0, 24) - 12, -1024, 1023);
      ry = clampv(tgt_y + $urandom_range(0, 24) - 12, -1024, 1023);
    end
    if (rx == tgt_x && ry == tgt_y) rx = (tgt_x == 1023) ? 1022 : tgt_x + 1;
    dx = tgt_x - rx;
    dy = tgt_y - ry;
    distance = int_sqrt(dx * dx + dy * dy);
    brg = bearing(dx, dy);
    case ($urandom_range(0, 9))
      0: hd = longint'($urandom_range(0, 32767)) - 16384;
      1: hd = longint'($urandom_range(0, 25736)) - 12868;
      default: hd = clampv(brg + longint'($urandom_range(0, 2 * head_tol + 6)) - head_tol - 3,
                           -16384, 16383);
    endcase
    case ($urandom_range(0, 3))
      0: f = around(obst_rng);
      1: f = around(distance * 256);
      2: f = $urandom_range(0, 65535);
      default: f = $urandom_range(0, 1) ? 65535 : $urandom_range(0, obst_rng > 65535 ? 65535 : obst_rng);
    endcase
    send_tick(rx, ry, hd, f, around($urandom_range(0, 1) ? near_rng : far_rng),
              around($urandom_range(0, 1) ? near_rng : far_rng));
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 5; ph++) begin
      write_target(longint'($urandom_range(0, 2047)) - 1024,
                   longint'($urandom_range(0, 2047)) - 1024);
      write_reg(bzn_pkg::RegHeadTol,
                (ph == 0) ? 0 : (ph == 4) ? 8191 : $urandom_range(0, 4096));
      write_reg(bzn_pkg::RegObstacle, (ph == 1) ? 65535 : $urandom_range(0, 3000));
      write_reg(bzn_pkg::RegNearWall, (ph == 2) ? 0 : $urandom_range(0, 400));
      write_reg(bzn_pkg::RegFarWall, (ph == 3) ? 65535 : $urandom_range(200, 800));
      for (int n = 0; n < 170; n++) begin
        quiet = (n >= 60 && n < 90);
        random_tick();
        // let the pipeline empty now and then
        if (ph == 2 && n % 40 == 39) drain();
      end
      quiet = 1'b0;
      drain();
    end
  endtask

  task automatic test_arrival;
    write_target(7, -9);
    send_facing(5, -9, 65535, 0, 0);
    send_tick(7, -9, 0, 0, 0, 0);
    // finished: inputs ignored, arrived follows distance
    send_tick(-1024, 1023, 16383, 0, 0, 65535);
    send_facing(100, 4, 65535, 65535, 0);
    send_tick(7, -9, -16384, 65535, 65535, 65535);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = bzn_pkg::RegTargetX;
    cfg_data = '0;
    m_tready = 1'b0;
    errors = 0;
    cycles = 0;
    stall = 0;
    quiet = 1'b0;
    tgt_x = 0; tgt_y = 0;
    head_tol = 205; obst_rng = 256; near_rng = 128; far_rng = 333;
    nav_mode = bzn_pkg::ModeDrive;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_extremes();
    test_random();
    test_arrival();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
